FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rlsfir_pkg.sv
// ----------------------------------------------------------------------------
// RLS adaptive FIR package
// Item types, command codes, register indexes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rlsfir_pkg;

	localparam int TAPS_DEF = 16;
	localparam int FRAC_DEF = 24;

	// Configuration register indexes.
	localparam logic [0:0] CFG_LAMBDA = 1'b0;
	localparam logic [0:0] CFG_DELTA  = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [24:0] RST_LAMBDA = 25'd16609444;
	localparam logic [30:0] RST_DELTA  = 31'd16777216;

	typedef enum logic [1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_READ    = 2'd1,
		CMD_WRITE   = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] ref_sample;
		logic signed [31:0] desired_sample;
		logic [3:0]         tap_index;
		logic signed [31:0] weight_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] error_out;
		logic signed [31:0] estimate_out;
		logic signed [31:0] weight_read;
	} out_item_t;

	// Saturate a 64-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return 32'(v);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rls_adaptive_fir_update_top.sv
// Sample step: its length is set by the P update, which steps through read, Q,
// T, D and write states per entry on one shared multiplier. Read weight passes
// a data read state, write weight goes straight to done, restart reruns the
// 1/lambda divide. One item is in work at a time; a stalled result holds the
// sequencer in its done state. Reset is asynchronous; the 1/lambda divide then
// runs before the first item is taken. P restarts as delta*I through a fresh flag.
// ----------------------------------------------------------------------------
// RLS adaptive FIR update, top level
// Sequencer over a tap memory (history, weights, gain) and a P memory, with
// one multiplier and a shared bit-serial reciprocal unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rls_adaptive_fir_update_top
	import rlsfir_pkg::*;
#(
	parameter int TAPS      = TAPS_DEF,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_idx,
	input  wire logic [30:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data
);

	localparam int TAW  = $clog2(TAPS);
	localparam int PAW  = 2 * TAW;
	localparam int QW   = 2 * FRAC_BITS + 1;
	localparam int DW   = 2 * FRAC_BITS + 2;
	localparam int BITW = $clog2(QW);
	localparam logic [DW-1:0] DEN_MAX = (DW'(1) << (2 * FRAC_BITS)) + DW'(1);
	localparam logic signed [63:0] NUM_ONE = 64'sd1 <<< (2 * FRAC_BITS);

	typedef enum logic [26:0] {
		S_IDLE  = 27'h0000001, S_LDIV  = 27'h0000002, S_RDDAT = 27'h0000004,
		S_EREAD = 27'h0000008, S_EMUL  = 27'h0000010, S_EACC  = 27'h0000020,
		S_EFIN  = 27'h0000040, S_GREAD = 27'h0000080, S_GMUL  = 27'h0000100,
		S_GACC  = 27'h0000200, S_GWR   = 27'h0000400, S_GGAM  = 27'h0000800,
		S_GDIV  = 27'h0001000, S_KMUL  = 27'h0002000, S_KSAT  = 27'h0004000,
		S_WREAD = 27'h0008000, S_WMUL  = 27'h0010000, S_WWR   = 27'h0020000,
		S_PROW  = 27'h0040000, S_PGI   = 27'h0080000, S_PREAD = 27'h0100000,
		S_PQ    = 27'h0200000, S_PT    = 27'h0400000, S_PD    = 27'h0800000,
		S_PWR   = 27'h1000000, S_DONE  = 27'h2000000, S_SPARE = 27'h4000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [24:0] lambda_q;
	logic [30:0] delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= RST_LAMBDA;
			delta_q  <= RST_DELTA;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_LAMBDA: lambda_q <= cfg_data[24:0];
				CFG_DELTA:  delta_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Tap memory (history, weights, gain) and P memory.
	logic signed [31:0] hist_mem [TAPS];
	logic signed [31:0] wgt_mem  [TAPS];
	logic signed [31:0] gain_mem [TAPS];
	logic signed [31:0] p_mem    [1 << PAW];

	logic [TAW-1:0]     i_q, j_q, tap_addr;
	logic [TAPS-1:0]    tap_vld_q;
	logic               tap_rvld_q;
	logic signed [31:0] hist_rd_q, wgt_rd_q, gain_rd_q, p_rd_q;
	logic               hist_we, wgt_we, gain_we, p_we;
	logic signed [31:0] hist_wd, wgt_wd, gain_wd, p_wd;
	logic [PAW-1:0]     p_addr;

	assign p_addr = {i_q, j_q};

	always_ff @(posedge clk) begin
		hist_rd_q <= hist_mem[tap_addr];
		wgt_rd_q  <= wgt_mem[tap_addr];
		gain_rd_q <= gain_mem[tap_addr];
		if (hist_we) begin
			hist_mem[tap_addr] <= hist_wd;
		end
		if (wgt_we) begin
			wgt_mem[tap_addr] <= wgt_wd;
		end
		if (gain_we) begin
			gain_mem[tap_addr] <= gain_wd;
		end
	end

	always_ff @(posedge clk) begin
		p_rd_q <= p_mem[p_addr];
		if (p_we) begin
			p_mem[p_addr] <= p_wd;
		end
	end

	// Datapath registers.
	logic signed [31:0] x_q, d_q, hcar_q, hi_q, gi_q, wh_q, pval_q;
	logic signed [31:0] err_q, inv_q, lrecip_q, k_q;
	logic signed [63:0] acc_q, gam_q, prod_q;
	logic [30:0]        p_diag_q;
	logic               p_fresh_q, boot_q;
	logic [DW-1:0]      den_q, rem_q;
	logic [QW-1:0]      quo_q;
	logic [BITW-1:0]    bit_q;
	out_item_t          res_q;
	logic               idx_ok_q;

	// Read data with tap entries cleared by restart reading as zero, and P as delta*I.
	logic signed [31:0] h_rd, w_rd, p_val;
	assign h_rd  = tap_rvld_q ? hist_rd_q : 32'sd0;
	assign w_rd  = tap_rvld_q ? wgt_rd_q  : 32'sd0;
	assign p_val = !p_fresh_q ? p_rd_q :
		((i_q == j_q) ? signed'({1'b0, p_diag_q}) : 32'sd0);

	logic               accept, idx_ok, i_last, j_last, div_last;
	logic signed [63:0] scaled, gam_tot;
	logic signed [31:0] prod_sat, hnew, g_new, t_val, d_val, est_val;
	logic [DW:0]        div_rs;
	logic               div_ge;
	logic [DW-1:0]      rem_nxt, den_gam;
	logic [QW-1:0]      quo_nxt;
	logic signed [31:0] quo_sat;

	assign accept   = in_valid && !in_stall;
	assign idx_ok   = in_data.tap_index < TAPS;
	assign i_last   = i_q == TAW'(TAPS - 1);
	assign j_last   = j_q == TAW'(TAPS - 1);
	assign scaled   = prod_q >>> FRAC_BITS;
	assign prod_sat = sat32(scaled);
	assign hnew     = (i_q == '0) ? x_q : hcar_q;
	assign g_new    = sat32(acc_q);
	assign t_val    = prod_sat;
	assign d_val    = sat32(64'(pval_q) - 64'(t_val));
	assign est_val  = sat32(acc_q);
	assign gam_tot  = gam_q + scaled;

	// Gamma clamped to one LSB below and to the range where 1/gamma is zero above.
	always_comb begin
		if (gam_tot < 64'sd1) begin
			den_gam = DW'(1);
		end else if (gam_tot > NUM_ONE) begin
			den_gam = DEN_MAX;
		end else begin
			den_gam = DW'(gam_tot);
		end
	end

	// One quotient bit per cycle of 2^(2F) / den, restoring division.
	assign div_last = bit_q == '0;
	assign div_rs   = {rem_q, (bit_q == BITW'(2 * FRAC_BITS))};
	assign div_ge   = div_rs >= (DW + 1)'(den_q);
	assign rem_nxt  = div_ge ? DW'(div_rs - (DW + 1)'(den_q)) : DW'(div_rs);
	assign quo_nxt  = {quo_q[QW-2:0], div_ge};
	assign quo_sat  = (64'(quo_nxt) > 64'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
		: signed'(32'(quo_nxt));

	// Tap memory address by phase.
	always_comb begin
		case (state_q)
			S_IDLE:          tap_addr = TAW'(in_data.tap_index);
			S_GREAD, S_PREAD: tap_addr = j_q;
			default:         tap_addr = i_q;
		endcase
	end

	// Memory write controls.
	always_comb begin
		hist_we = 1'b0;
		wgt_we  = 1'b0;
		gain_we = 1'b0;
		p_we    = 1'b0;
		hist_wd = 32'sd0;
		wgt_wd  = w_rd;
		gain_wd = g_new;
		p_wd    = prod_sat;
		case (state_q)
			S_IDLE: begin
				if (accept && in_data.cmd == CMD_WRITE && idx_ok) begin
					hist_we = !tap_vld_q[tap_addr];
					wgt_we  = 1'b1;
					wgt_wd  = in_data.weight_value;
				end
			end
			S_EMUL: begin
				hist_we = 1'b1;
				hist_wd = hnew;
				wgt_we  = 1'b1;
			end
			S_GWR:   gain_we = 1'b1;
			S_WWR: begin
				wgt_we = 1'b1;
				wgt_wd = sat32(64'(wh_q) + scaled);
			end
			S_PWR:   p_we = 1'b1;
			default: ;
		endcase
	end

	// Shared multiplier operands.
	logic signed [31:0] mul_a, mul_b;
	always_comb begin
		mul_a = 32'sd0;
		mul_b = 32'sd0;
		case (state_q)
			S_EMUL: begin
				mul_a = w_rd;
				mul_b = hnew;
			end
			S_GMUL: begin
				mul_a = p_val;
				mul_b = h_rd;
			end
			S_GWR: begin
				mul_a = hi_q;
				mul_b = g_new;
			end
			S_KMUL: begin
				mul_a = err_q;
				mul_b = inv_q;
			end
			S_WMUL, S_PQ: begin
				mul_a = (state_q == S_PQ) ? gi_q : k_q;
				mul_b = gain_rd_q;
			end
			S_PT: begin
				mul_a = prod_sat;
				mul_b = inv_q;
			end
			S_PD: begin
				mul_a = d_val;
				mul_b = lrecip_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LDIV;
			boot_q     <= 1'b1;
			tap_vld_q  <= '0;
			tap_rvld_q <= 1'b0;
			p_fresh_q  <= 1'b1;
			p_diag_q   <= RST_DELTA;
			den_q      <= DW'(RST_LAMBDA);
			rem_q      <= '0;
			quo_q      <= '0;
			bit_q      <= BITW'(2 * FRAC_BITS);
			lrecip_q   <= 32'sd0;
			i_q        <= '0;
			j_q        <= '0;
			out_valid  <= 1'b0;
		end else begin
			tap_rvld_q <= tap_vld_q[tap_addr];
			if (hist_we || wgt_we) begin
				tap_vld_q[tap_addr] <= 1'b1;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (state_q == S_LDIV || state_q == S_GDIV) begin
				rem_q <= rem_nxt;
				quo_q <= quo_nxt;
				bit_q <= bit_q - BITW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						i_q   <= '0;
						j_q   <= '0;
						case (in_data.cmd)
							CMD_SAMPLE:  state_q <= S_EREAD;
							CMD_READ:    state_q <= S_RDDAT;
							CMD_WRITE:   state_q <= S_DONE;
							CMD_RESTART: begin
								tap_vld_q <= '0;
								p_fresh_q <= 1'b1;
								p_diag_q  <= delta_q;
								den_q     <= DW'(lambda_q);
								rem_q     <= '0;
								quo_q     <= '0;
								bit_q     <= BITW'(2 * FRAC_BITS);
								state_q   <= S_LDIV;
							end
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_LDIV: begin
					if (div_last) begin
						lrecip_q <= quo_sat;
						boot_q   <= 1'b0;
						state_q  <= boot_q ? S_IDLE : S_DONE;
					end
				end
				S_RDDAT:  state_q <= S_DONE;
				S_EREAD:  state_q <= S_EMUL;
				S_EMUL:   state_q <= S_EACC;
				S_EACC: begin
					i_q     <= i_q + TAW'(1);
					state_q <= i_last ? S_EFIN : S_EREAD;
				end
				S_EFIN: begin
					i_q     <= '0;
					state_q <= S_GREAD;
				end
				S_GREAD:  state_q <= S_GMUL;
				S_GMUL:   state_q <= S_GACC;
				S_GACC: begin
					j_q     <= j_q + TAW'(1);
					state_q <= j_last ? S_GWR : S_GREAD;
				end
				S_GWR:    state_q <= S_GGAM;
				S_GGAM: begin
					if (i_last) begin
						den_q   <= den_gam;
						rem_q   <= '0;
						quo_q   <= '0;
						bit_q   <= BITW'(2 * FRAC_BITS);
						state_q <= S_GDIV;
					end else begin
						i_q     <= i_q + TAW'(1);
						j_q     <= '0;
						state_q <= S_GREAD;
					end
				end
				S_GDIV: begin
					if (div_last) begin
						state_q <= S_KMUL;
					end
				end
				S_KMUL:   state_q <= S_KSAT;
				S_KSAT: begin
					i_q     <= '0;
					state_q <= S_WREAD;
				end
				S_WREAD:  state_q <= S_WMUL;
				S_WMUL:   state_q <= S_WWR;
				S_WWR: begin
					i_q     <= i_last ? '0 : i_q + TAW'(1);
					state_q <= i_last ? S_PROW : S_WREAD;
				end
				S_PROW:   state_q <= S_PGI;
				S_PGI: begin
					j_q     <= '0;
					state_q <= S_PREAD;
				end
				S_PREAD:  state_q <= S_PQ;
				S_PQ:     state_q <= S_PT;
				S_PT:     state_q <= S_PD;
				S_PD:     state_q <= S_PWR;
				S_PWR: begin
					j_q <= j_q + TAW'(1);
					if (!j_last) begin
						state_q <= S_PREAD;
					end else if (i_last) begin
						p_fresh_q <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						i_q     <= i_q + TAW'(1);
						state_q <= S_PROW;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers of the step.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q   <= in_data.ref_sample;
					d_q   <= in_data.desired_sample;
					res_q <= '0;
				end
			end
			S_RDDAT: begin
				res_q.weight_read <= idx_ok_q ? w_rd : 32'sd0;
			end
			S_EREAD: begin
				if (i_q == '0) begin
					acc_q <= 64'sd0;
				end
			end
			S_EMUL:   hcar_q <= h_rd;
			S_EACC:   acc_q  <= acc_q + scaled;
			S_EFIN: begin
				res_q.estimate_out <= est_val;
				res_q.error_out    <= sat32(64'(d_q) - 64'(est_val));
				err_q              <= sat32(64'(d_q) - 64'(est_val));
				acc_q              <= 64'sd0;
				gam_q              <= 64'(signed'({1'b0, lambda_q}));
			end
			S_GMUL: begin
				if (j_q == i_q) begin
					hi_q <= h_rd;
				end
			end
			S_GACC:   acc_q <= acc_q + scaled;
			S_GGAM: begin
				gam_q <= gam_tot;
				acc_q <= 64'sd0;
			end
			S_GDIV: begin
				if (div_last) begin
					inv_q <= quo_sat;
				end
			end
			S_KSAT:   k_q  <= prod_sat;
			S_WMUL:   wh_q <= w_rd;
			S_PGI:    gi_q <= gain_rd_q;
			S_PQ:     pval_q <= p_val;
			S_DONE: begin
				if (!out_valid || !out_stall) begin
					out_data <= res_q;
				end
			end
			default: ;
		endcase
	end

	// Whether the read command addressed an existing tap.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_ok_q <= idx_ok;
		end
	end

	assign in_stall = state_q != S_IDLE;

	// P leaves its restart form only when the update has written every entry.
	`ASSERT_IMPLY(a_fresh_end, clk, arst_n, $fell(p_fresh_q), $past(state_q) == S_PWR,
		"P fresh flag cleared outside the P update")
	// The estimate pass has rewritten every tap before the weight pass.
	`ASSERT_IMPLY(a_taps_valid, clk, arst_n, state_q == S_WREAD, &tap_vld_q,
		"weight pass on a tap the estimate pass did not write")
	// An accepted item always starts work.
	`ASSERT_NEXT(a_item_starts, clk, arst_n, in_valid && !in_stall, state_q != S_IDLE,
		"accepted item left the sequencer idle")

endmodule

`default_nettype wire
